### rtl/core/vpp_pkg.sv
// ----------------------------------------------------------------------------
// vpp_pkg
// shared widths, register indexes and helpers for the vertex projection block
// ----------------------------------------------------------------------------
package vpp_pkg;

  localparam int COEF_WIDTH = 16;              // kept top bits of each coefficient
  localparam int COEF_SLOT  = 16;              // slot width in a matrix row
  localparam int VERT_W     = 32;              // q16.16 vertex field
  localparam int PROD_W     = COEF_SLOT + VERT_W;
  localparam int PAIR_W     = PROD_W + 1;
  localparam int SUM_W      = PROD_W + 2;      // transformed coordinate
  localparam int NUM_W      = SUM_W + 1;       // t + tw
  localparam int MAG_W      = SUM_W;           // magnitudes of numerator / divisor
  localparam int SCALE_W    = 13;              // viewport width / height
  localparam int AMUL_W     = 63;              // magnitude times scale
  localparam int FRAC_SHIFT = 15;              // times 2^15 before the divide
  localparam int QB         = 41;              // quotient bits, cap is 2^40
  localparam int DIV_LAT    = QB + 1;          // divider register stages
  localparam int OUT_W      = 32;
  localparam int FIN_W      = QB + 2;          // screen values before clamp

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_ADDR_W-1:0] REG_ROW0   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ROW1   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ROW2   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_ROW3   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_WIDTH  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT = 3'd5;

  localparam logic [COEF_SLOT-1:0] COEF_MASK =
    COEF_SLOT'({COEF_SLOT{1'b1}} << (COEF_SLOT - COEF_WIDTH));

  // sideband that travels beside the divider
  typedef struct packed {
    logic valid;
    logic neg_x;
    logic neg_y;
    logic zero_w;
  } side_t;

  function automatic logic signed [COEF_SLOT-1:0] coef_of(
      input logic [CFG_DATA_W-1:0] row, input int col);
    logic [COEF_SLOT-1:0] slot;
    slot = row[COEF_SLOT*col +: COEF_SLOT] & COEF_MASK;
    return $signed(slot);
  endfunction

endpackage

### rtl/core/vpp_div.sv
// ----------------------------------------------------------------------------
// vpp_div
// pipelined restoring divider, one quotient bit per stage, capped at 2^40
// ----------------------------------------------------------------------------
module vpp_div (
  input  logic                        clk,
  input  logic                        ce,
  input  logic [vpp_pkg::AMUL_W-1:0]  a_in,   // dividend before the 2^15 shift
  input  logic [vpp_pkg::MAG_W-1:0]   d_in,
  output logic [vpp_pkg::QB-1:0]      q_out
);
  import vpp_pkg::*;

  localparam int N_W = AMUL_W + FRAC_SHIFT;
  localparam logic [QB-1:0] CAP = QB'(1) << (QB - 1);

  logic [N_W-1:0]   n_full;
  logic [MAG_W-1:0] rem_r [DIV_LAT];
  logic [QB-1:0]    low_r [DIV_LAT];
  logic [QB-1:0]    q_r   [DIV_LAT];
  logic [MAG_W-1:0] d_r   [DIV_LAT];
  logic             ovf_r [DIV_LAT];
  logic [QB-1:0]    q_last;

  assign n_full = {a_in, FRAC_SHIFT'(0)};

  // entry: upper bits as the first remainder, quotient overflow if they reach d
  always_ff @(posedge clk) begin
    if (ce) begin
      rem_r[0] <= MAG_W'(n_full[N_W-1:QB]);
      low_r[0] <= n_full[QB-1:0];
      q_r[0]   <= '0;
      d_r[0]   <= d_in;
      ovf_r[0] <= MAG_W'(n_full[N_W-1:QB]) >= d_in;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [MAG_W:0] shifted;
    logic [MAG_W+1:0] trial;
    logic ge;

    assign shifted = {rem_r[k], low_r[k][QB-1]};
    assign trial   = {1'b0, shifted} - {2'b00, d_r[k]};
    assign ge      = !trial[MAG_W+1];

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[k+1] <= ge ? trial[MAG_W-1:0] : shifted[MAG_W-1:0];
        low_r[k+1] <= {low_r[k][QB-2:0], 1'b0};
        q_r[k+1]   <= {q_r[k][QB-2:0], ge};
        d_r[k+1]   <= d_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end
    end
  end

  assign q_last = q_r[QB];
  assign q_out  = (ovf_r[QB] || (q_last[QB-1] && |q_last[QB-2:0])) ? CAP : q_last;

endmodule

### rtl/core/vertex_perspective_projection.sv
// ----------------------------------------------------------------------------
// vertex_perspective_projection
// 4x4 matrix transform, perspective divide and viewport mapping of vertices
// ----------------------------------------------------------------------------
// usage:
//   in_*  : one homogeneous vertex per word, x y z w in signed q16.16
//   out_* : one word per vertex, screen x / y in signed q16.16 (origin top
//           left, y flipped) plus a zero-w flag and a saturation flag
//   cfg_* : matrix rows 0..3 (four q4.12 coefficients each, column 0 lowest)
//           and viewport width / height; write only while the block is idle
// throughput: one vertex per clock, sustained
// latency: 49 cycles from the accepting edge to out_tvalid; set by the
//   41-stage divider (one quotient bit per stage) plus transform, scale and
//   clamp stages
// reset: matrix becomes identity, viewport 640 x 480, pipeline emptied
// stall: the pipeline keeps running into a one-word skid register while the
//   output word waits; only when the skid is full does in_tready drop, and
//   then every stage holds
// zero transformed w gives zero coordinates with the zero-w flag set
// ----------------------------------------------------------------------------
module vertex_perspective_projection (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [127:0]                    in_tdata,   // vert_x, vert_y, vert_z, vert_w
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [71:0]                     out_tdata,  // screen_x, screen_y,
                                                      // zero_w_flag, saturated_flag, pad
  input  logic                            cfg_we,
  input  logic [vpp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [vpp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import vpp_pkg::*;

  localparam int RES_W = 2 * OUT_W + 2;

  // configuration registers
  logic [CFG_DATA_W-1:0] row0_r, row1_r, row2_r, row3_r;
  logic [SCALE_W-1:0]    width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row0_r   <= CFG_DATA_W'(64'h0000_0000_0000_1000);
      row1_r   <= CFG_DATA_W'(64'h0000_0000_1000_0000);
      row2_r   <= CFG_DATA_W'(64'h0000_1000_0000_0000);
      row3_r   <= CFG_DATA_W'(64'h1000_0000_0000_0000);
      width_r  <= SCALE_W'(640);
      height_r <= SCALE_W'(480);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ROW0:   row0_r   <= cfg_wdata;
        REG_ROW1:   row1_r   <= cfg_wdata;
        REG_ROW2:   row2_r   <= cfg_wdata;
        REG_ROW3:   row3_r   <= cfg_wdata;
        REG_WIDTH:  width_r  <= cfg_wdata[SCALE_W-1:0];
        REG_HEIGHT: height_r <= cfg_wdata[SCALE_W-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // row 2 (transformed z) is not needed for the outputs
  logic unused_row2;
  assign unused_row2 = ^row2_r;

  // global advance: stages move whenever the skid register is free
  logic skid_v_r;
  logic ce;
  assign ce        = !skid_v_r;
  assign in_tready = ce;

  // stage 1: twelve products, rows x, y and w
  logic signed [VERT_W-1:0]  vert [4];
  logic [CFG_DATA_W-1:0]     row_sel [3];
  logic signed [PROD_W-1:0]  prod_nxt [3][4];
  logic signed [PROD_W-1:0]  prod_r   [3][4];
  logic                      s1_v_r;

  assign row_sel[0] = row0_r;
  assign row_sel[1] = row1_r;
  assign row_sel[2] = row3_r;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      vert[c] = $signed(in_tdata[VERT_W*c +: VERT_W]);
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        prod_nxt[r][c] = coef_of(row_sel[r], c) * vert[c];
      end
    end
  end

  // stage 2: pair sums, stage 3: row sums
  logic signed [PAIR_W-1:0] pair_r [3][2];
  logic signed [SUM_W-1:0]  t_r [3];
  logic                     s2_v_r, s3_v_r;

  // stage 4: magnitudes and signs
  logic signed [NUM_W-1:0]  num_x, num_y;
  logic signed [SUM_W-1:0]  tw;
  logic [MAG_W-1:0]         mag_x_r, mag_y_r, mag_d_r;
  side_t                    s4_r, s5_r;

  assign tw    = t_r[2];
  assign num_x = NUM_W'(t_r[0]) + NUM_W'(tw);
  assign num_y = NUM_W'(t_r[1]) + NUM_W'(tw);

  // stage 5: scale by viewport size
  logic [AMUL_W-1:0] ax_r, ay_r;
  logic [MAG_W-1:0]  d5_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      prod_r <= prod_nxt;
      for (int r = 0; r < 3; r++) begin
        pair_r[r][0] <= PAIR_W'(prod_r[r][0]) + PAIR_W'(prod_r[r][1]);
        pair_r[r][1] <= PAIR_W'(prod_r[r][2]) + PAIR_W'(prod_r[r][3]);
        t_r[r]       <= SUM_W'(pair_r[r][0]) + SUM_W'(pair_r[r][1]);
      end
      mag_x_r <= MAG_W'(num_x[NUM_W-1] ? -num_x : num_x);
      mag_y_r <= MAG_W'(num_y[NUM_W-1] ? -num_y : num_y);
      mag_d_r <= MAG_W'(tw[SUM_W-1] ? -tw : tw);
      ax_r    <= AMUL_W'(mag_x_r) * AMUL_W'(width_r);
      ay_r    <= AMUL_W'(mag_y_r) * AMUL_W'(height_r);
      d5_r    <= mag_d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_r   <= '0;
      s5_r   <= '0;
    end else if (ce) begin
      s1_v_r       <= in_tvalid;
      s2_v_r       <= s1_v_r;
      s3_v_r       <= s2_v_r;
      s4_r.valid   <= s3_v_r;
      s4_r.neg_x   <= num_x[NUM_W-1] != tw[SUM_W-1];
      s4_r.neg_y   <= num_y[NUM_W-1] != tw[SUM_W-1];
      s4_r.zero_w  <= tw == '0;
      s5_r         <= s4_r;
    end
  end

  // dividers, sideband delayed alongside
  logic [QB-1:0] qx, qy;
  side_t         sb_r [DIV_LAT];

  vpp_div u_div_x (.clk(clk), .ce(ce), .a_in(ax_r), .d_in(d5_r), .q_out(qx));
  vpp_div u_div_y (.clk(clk), .ce(ce), .a_in(ay_r), .d_in(d5_r), .q_out(qy));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) sb_r[i] <= '0;
    end else if (ce) begin
      sb_r[0] <= s5_r;
      for (int i = 1; i < DIV_LAT; i++) sb_r[i] <= sb_r[i-1];
    end
  end

  // f1: signed quotients, flip y against the top row
  side_t                   f1_r;
  logic signed [FIN_W-1:0] sx_r, sy_r;
  logic signed [FIN_W-1:0] qx_s, qy_s, top_s;

  assign qx_s  = sb_r[DIV_LAT-1].neg_x ? -FIN_W'(qx) : FIN_W'(qx);
  assign qy_s  = sb_r[DIV_LAT-1].neg_y ? -FIN_W'(qy) : FIN_W'(qy);
  assign top_s = (FIN_W'(height_r) - FIN_W'(1)) <<< 16;

  always_ff @(posedge clk) begin
    if (ce) begin
      sx_r <= qx_s;
      sy_r <= top_s - qy_s;
    end
  end

  // f2: clamp to 32 bits and flags
  function automatic logic [OUT_W:0] clamp32(input logic signed [FIN_W-1:0] v);
    logic signed [FIN_W-1:0] hi, lo;
    hi = FIN_W'(32'sh7FFF_FFFF);
    lo = -FIN_W'(33'sh0_8000_0000);
    if (v > hi)      return {1'b1, 32'h7FFF_FFFF};
    else if (v < lo) return {1'b1, 32'h8000_0000};
    else             return {1'b0, v[OUT_W-1:0]};
  endfunction

  logic [OUT_W:0]   cx, cy;
  logic             fin_v_r;
  logic [RES_W-1:0] fin_r;

  assign cx = clamp32(sx_r);
  assign cy = clamp32(sy_r);

  always_ff @(posedge clk) begin
    if (ce) begin
      if (f1_r.zero_w) begin
        fin_r <= {1'b0, 1'b1, {2*OUT_W{1'b0}}};
      end else begin
        fin_r <= {cx[OUT_W] | cy[OUT_W], 1'b0, cy[OUT_W-1:0], cx[OUT_W-1:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_r    <= '0;
      fin_v_r <= 1'b0;
    end else if (ce) begin
      f1_r    <= sb_r[DIV_LAT-1];
      fin_v_r <= f1_r.valid;
    end
  end

  // output register and skid register
  logic             out_v_r;
  logic [RES_W-1:0] out_r, skid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (ce) begin
      if (fin_v_r) begin
        if (!out_v_r || out_tready) out_v_r <= 1'b1;
        else                        skid_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end else if (out_tready) begin
      skid_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      if (fin_v_r) begin
        if (!out_v_r || out_tready) out_r  <= fin_r;
        else                        skid_r <= fin_r;
      end
    end else if (out_tready) begin
      out_r <= skid_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'b0, out_r};

  // checks
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid word held while output register empty");

  a_frozen_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !ce |=> $stable(fin_v_r) && $stable(fin_r))
    else $error("final stage moved while pipeline stalled");

  a_zero_w_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r[2*OUT_W] |-> out_r[2*OUT_W-1:0] == '0 && !out_r[2*OUT_W+1])
    else $error("zero w word carries coordinates or saturation");

endmodule
